[rtl/par_pkg.sv]
package par_pkg;

    localparam int WORD_W = 32;
    localparam int PROD_W = 2 * WORD_W;
    localparam int CNT_W  = $clog2(PROD_W);

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_NUM,
        S_MUL_DEN,
        S_TEST,
        S_GCD,
        S_DIVN_GO,
        S_DIVN,
        S_DIVD_GO,
        S_DIVD,
        S_CHECK,
        S_RESTART,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul_num;
        logic mul_den;
        logic gcd_init;
        logic gcd_step;
        logic gcd_fin;
        logic div_start;
        logic div_wr;
        logic div_den;
        logic shift;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic prod_zero;
        logic gcd_done;
        logic div_done;
        logic fits;
    } t_sts;

endpackage

[rtl/par_div.sv]
module par_div
    import par_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_dividend,
    input  logic [PROD_W-1:0] i_divisor,
    output logic [PROD_W-1:0] o_quot,
    output logic              o_done
);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [PROD_W-1:0] r_rem;
    logic [PROD_W-1:0] r_quo;

    logic [PROD_W:0]   w_trial;
    logic [PROD_W:0]   w_diff;
    logic              w_ge;

    // One restoring step per cycle: shift in the next dividend bit and
    // subtract the divisor when it fits.
    always_comb begin
        w_trial = {r_rem, r_quo[PROD_W-1]};
        w_diff  = w_trial - {1'b0, i_divisor};
        w_ge    = (w_trial >= {1'b0, i_divisor});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[PROD_W-1:0] : w_trial[PROD_W-1:0];
            r_quo <= {r_quo[PROD_W-2:0], w_ge};
        end
    end

    assign o_quot = r_quo;
    assign o_done = r_done;

endmodule

[rtl/par_dp.sv]
module par_dp
    import par_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [WORD_W-1:0] i_frame_w,
    input  logic [WORD_W-1:0] i_frame_h,
    input  logic [WORD_W-1:0] i_disp_w,
    input  logic [WORD_W-1:0] i_disp_h,
    output t_sts              o_sts,
    output logic [WORD_W-1:0] o_par_w,
    output logic [WORD_W-1:0] o_par_h
);

    logic [WORD_W-1:0] r_fw, r_fh, r_dw, r_dh;
    logic [PROD_W-1:0] r_num, r_den;
    logic [PROD_W-1:0] r_gx, r_gy, r_g;
    logic [CNT_W-1:0]  r_gk;

    logic [WORD_W-1:0] w_op_a, w_op_b;
    logic [PROD_W-1:0] w_prod;
    logic [PROD_W-1:0] w_dividend;
    logic [PROD_W-1:0] w_quot;
    logic              w_div_done;
    logic [PROD_W-1:0] w_gcd_odd;

    // One shared multiplier, used for the numerator and then the denominator.
    always_comb begin
        w_op_a = i_cmd.mul_den ? r_dh : r_dw;
        w_op_b = i_cmd.mul_den ? r_fw : r_fh;
        w_prod = PROD_W'(w_op_a) * PROD_W'(w_op_b);
    end

    assign w_dividend = i_cmd.div_den ? r_den : r_num;
    assign w_gcd_odd  = (r_gx == '0) ? r_gy : r_gx;

    par_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_g),
        .o_quot     (w_quot),
        .o_done     (w_div_done)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_fw <= i_frame_w;
            r_fh <= i_frame_h;
            r_dw <= i_disp_w;
            r_dh <= i_disp_h;
        end

        if (i_cmd.mul_num) begin
            r_num <= w_prod;
        end else if (i_cmd.div_wr && !i_cmd.div_den) begin
            r_num <= w_quot;
        end else if (i_cmd.shift) begin
            r_num <= r_num >> 1;
        end

        if (i_cmd.mul_den) begin
            r_den <= w_prod;
        end else if (i_cmd.div_wr && i_cmd.div_den) begin
            r_den <= w_quot;
        end else if (i_cmd.shift) begin
            r_den <= r_den >> 1;
        end

        // Binary GCD: strip common factors of two, then subtract odd terms.
        if (i_cmd.gcd_init) begin
            r_gx <= r_num;
            r_gy <= r_den;
            r_gk <= '0;
        end else if (i_cmd.gcd_step) begin
            priority if (!r_gx[0] && !r_gy[0]) begin
                r_gx <= r_gx >> 1;
                r_gy <= r_gy >> 1;
                r_gk <= r_gk + 1'b1;
            end else if (!r_gx[0]) begin
                r_gx <= r_gx >> 1;
            end else if (!r_gy[0]) begin
                r_gy <= r_gy >> 1;
            end else if (r_gx >= r_gy) begin
                r_gx <= r_gx - r_gy;
            end else begin
                r_gy <= r_gy - r_gx;
            end
        end

        if (i_cmd.gcd_fin) begin
            r_g <= w_gcd_odd << r_gk;
        end
    end

    always_comb begin
        o_sts.prod_zero = (r_num == '0) || (r_den == '0);
        o_sts.gcd_done  = (r_gx == '0) || (r_gy == '0);
        o_sts.div_done  = w_div_done;
        o_sts.fits      = (r_num[PROD_W-1:WORD_W] == '0) && (r_den[PROD_W-1:WORD_W] == '0);
    end

    assign o_par_w = r_num[WORD_W-1:0];
    assign o_par_h = r_den[WORD_W-1:0];

endmodule

[rtl/par_ctrl.sv]
module par_ctrl
    import par_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy,
    output logic o_valid
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != S_IDLE);
        o_valid = (r_state == S_DONE);
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL_NUM;
                end
            end
            S_MUL_NUM: begin
                o_cmd.mul_num = 1'b1;
                n_state       = S_MUL_DEN;
            end
            S_MUL_DEN: begin
                o_cmd.mul_den = 1'b1;
                n_state       = S_TEST;
            end
            S_TEST: begin
                if (i_sts.prod_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.gcd_init = 1'b1;
                    n_state        = S_GCD;
                end
            end
            S_GCD: begin
                if (i_sts.gcd_done) begin
                    o_cmd.gcd_fin = 1'b1;
                    n_state       = S_DIVN_GO;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DIVN_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIVN;
            end
            S_DIVN: begin
                if (i_sts.div_done) begin
                    o_cmd.div_wr = 1'b1;
                    n_state      = S_DIVD_GO;
                end
            end
            S_DIVD_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_den   = 1'b1;
                n_state         = S_DIVD;
            end
            S_DIVD: begin
                o_cmd.div_den = 1'b1;
                if (i_sts.div_done) begin
                    o_cmd.div_wr = 1'b1;
                    n_state      = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.fits) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.shift = 1'b1;
                    n_state     = S_RESTART;
                end
            end
            S_RESTART: begin
                o_cmd.gcd_init = 1'b1;
                n_state        = S_GCD;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/pixel_aspect_ratio_reducer.sv]
// Pixel aspect ratio reducer.
// A transaction is taken at a rising edge where start is high and busy is low;
// the four 32-bit sizes are sampled then and may change afterwards.
// The block forms disp_w*frame_h and disp_h*frame_w on one shared multiplier,
// then reduces the pair by its GCD (a zero product skips this), shifting both
// terms right and reducing again while either term needs more than 32 bits.
// The result appears on o_par_w/o_par_h for exactly one cycle with o_valid
// high; the receiver has no way to hold it off and must take it then.
// The two 64-bit divisions by the GCD share one bit-serial divider of 64
// steps each. One transaction is in flight at a time: busy stays high from
// the accepting edge through the strobe cycle.
// Reset returns the controller to idle and drops any transaction in progress.
module pixel_aspect_ratio_reducer
    import par_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [WORD_W-1:0] i_frame_w,
    input  logic [WORD_W-1:0] i_frame_h,
    input  logic [WORD_W-1:0] i_disp_w,
    input  logic [WORD_W-1:0] i_disp_h,
    output logic              o_valid,
    output logic [WORD_W-1:0] o_par_w,
    output logic [WORD_W-1:0] o_par_h
);

    t_cmd w_cmd;
    t_sts w_sts;

    // The controller sequences multiply, GCD, divide and range check passes.
    par_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    // The datapath holds the operands, the GCD registers and the divider.
    par_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_frame_w (i_frame_w),
        .i_frame_h (i_frame_h),
        .i_disp_w  (i_disp_w),
        .i_disp_h  (i_disp_h),
        .o_sts     (w_sts),
        .o_par_w   (o_par_w),
        .o_par_h   (o_par_h)
    );

endmodule

[dv/pixel_aspect_ratio_reducer_tb.sv]
module pixel_aspect_ratio_reducer_tb;

    import par_pkg::*;

    // The directed cases come first. The rest of the item list is random, up to this total.
    localparam int NUM_ITEMS   = 1350;
    // Drain points: the sender waits for every outstanding result before presenting
    // the first random item, and before each multiple of DRAIN_EVERY.
    localparam int DRAIN_EVERY = 250;
    // Guard against a hung block. The slowest legal run is around 1350 transactions
    // of roughly 33 reduction passes each. This limit allows several times that.
    localparam int CYCLE_LIMIT = 70_000_000;
    // Quiet cycles after the last result, so that a stray strobe is still caught.
    localparam int TAIL_CYCLES = 32;

    typedef struct packed {
        logic [WORD_W-1:0] frame_w;
        logic [WORD_W-1:0] frame_h;
        logic [WORD_W-1:0] disp_w;
        logic [WORD_W-1:0] disp_h;
    } t_sizes;

    typedef struct packed {
        logic [WORD_W-1:0] par_w;
        logic [WORD_W-1:0] par_h;
    } t_ratio;

    // Every input starts at a known value. Reset is held low from time zero.
    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              start     = 1'b0;
    logic [WORD_W-1:0] i_frame_w = '0;
    logic [WORD_W-1:0] i_frame_h = '0;
    logic [WORD_W-1:0] i_disp_w  = '0;
    logic [WORD_W-1:0] i_disp_h  = '0;
    logic              busy;
    logic              o_valid;
    logic [WORD_W-1:0] o_par_w;
    logic [WORD_W-1:0] o_par_h;

    // pending_sizes: items the driver has not yet presented.
    // expected_par: one predicted ratio for each accepted transaction, oldest first.
    t_sizes pending_sizes[$];
    t_ratio expected_par[$];
    int     num_directed;

    // n_accepted and n_checked change only through nonblocking updates. The driver
    // and the monitor therefore both see the values from before the edge, and the
    // number of transactions in flight does not depend on which block runs first.
    int     n_accepted  = 0;
    int     n_checked   = 0;
    int     n_errors    = 0;
    int     n_zero_prod = 0;
    int     n_big_field = 0;
    int     cycle_count = 0;

    pixel_aspect_ratio_reducer dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_frame_w (i_frame_w),
        .i_frame_h (i_frame_h),
        .i_disp_w  (i_disp_w),
        .i_disp_h  (i_disp_h),
        .o_valid   (o_valid),
        .o_par_w   (o_par_w),
        .o_par_h   (o_par_h)
    );

    always #2 i_clk = ~i_clk;

    // Predicts the reduced pixel aspect ratio for one set of frame and display sizes.
    // The block divides the exact 64-bit pair disp_w*frame_h : disp_h*frame_w by its
    // GCD. While either term is still wider than 32 bits, it halves both terms and
    // reduces again. A zero product leaves the pair as it is, cut to 32 bits.
    function automatic t_ratio reduce_par(t_sizes s);
        logic [PROD_W-1:0] num;
        logic [PROD_W-1:0] den;
        logic [PROD_W-1:0] x;
        logic [PROD_W-1:0] y;
        logic [PROD_W-1:0] r;
        logic              fits;
        t_ratio            res;
        num = {{WORD_W{1'b0}}, s.disp_w} * {{WORD_W{1'b0}}, s.frame_h};
        den = {{WORD_W{1'b0}}, s.disp_h} * {{WORD_W{1'b0}}, s.frame_w};
        if (num != 0 && den != 0) begin
            fits = 1'b0;
            while (!fits) begin
                x = num;
                y = den;
                while (y != 0) begin
                    r = x % y;
                    x = y;
                    y = r;
                end
                if (x != 0) begin
                    num = num / x;
                    den = den / x;
                end
                fits = (num >> WORD_W) == 0 && (den >> WORD_W) == 0;
                if (!fits) begin
                    // Halving can take the smaller term to zero. The next GCD is then
                    // the other term, and the pair ends as 1:0 or 0:1.
                    num = num >> 1;
                    den = den >> 1;
                end
            end
        end
        res.par_w = num[WORD_W-1:0];
        res.par_h = den[WORD_W-1:0];
        return res;
    endfunction

    // Driver. It presents one item at a time and holds it until the edge where start is
    // high and busy is low. After that edge it sometimes leaves start low for a burst
    // of random length. The burst counts down only while busy is low, so the idle
    // time lands after the block has gone idle, and not in the middle of a long
    // reduction where the block would hide it.
    t_sizes cur_sizes;
    int     gap_left     = 0;
    int     items_driven = 0;
    logic   took;
    logic   quiet;
    int     in_flight;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left = 0;
        end else begin
            took = start && !busy;
            // Two stretches of idling alternate with one stretch without it.
            // The last part of the run has no idling at all.
            quiet = pending_sizes.size() < 150 || ((items_driven / 100) % 3) == 2;
            if (took) begin
                expected_par.push_back(reduce_par(cur_sizes));
                n_accepted <= n_accepted + 1;
                if (cur_sizes.frame_w == 0 || cur_sizes.frame_h == 0 ||
                    cur_sizes.disp_w == 0 || cur_sizes.disp_h == 0)
                    n_zero_prod++;
                else if ((cur_sizes.frame_w | cur_sizes.frame_h |
                          cur_sizes.disp_w | cur_sizes.disp_h) >> 16 != 0)
                    n_big_field++;
                if (!quiet && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 16);
            end
            // The count does not yet include a transaction taken at this edge, so it is
            // added by hand.
            in_flight = n_accepted - n_checked + (took ? 1 : 0);

            if (start && !took) begin
                // The block is still busy. The same transaction stays on the ports.
            end else if (gap_left > 0) begin
                start <= 1'b0;
                if (!busy)
                    gap_left--;
            end else if (pending_sizes.size() == 0) begin
                start <= 1'b0;
            end else if ((items_driven == num_directed ||
                          (items_driven % DRAIN_EVERY == 0 && items_driven > 0)) &&
                         in_flight != 0) begin
                // Drain point: wait for every outstanding result before the next item.
                start <= 1'b0;
            end else begin
                cur_sizes = pending_sizes.pop_front();
                i_frame_w <= cur_sizes.frame_w;
                i_frame_h <= cur_sizes.frame_h;
                i_disp_w  <= cur_sizes.disp_w;
                i_disp_h  <= cur_sizes.disp_h;
                start     <= 1'b1;
                items_driven++;
            end
        end
    end

    // Monitor. A result is valid for exactly one cycle and is taken at the edge that
    // ends that cycle.
    t_ratio want;

    always @(posedge i_clk) begin
        if (i_rst_n && $isunknown(o_valid)) begin
            n_errors++;
            $display("%0t: o_valid is unknown, expected 0 or 1, actual %b", $time, o_valid);
        end else if (i_rst_n && o_valid) begin
            if (n_accepted == n_checked) begin
                n_errors++;
                $display("%0t: result with no transaction outstanding, expected none, actual %0d:%0d",
                         $time, o_par_w, o_par_h);
            end else begin
                want = expected_par.pop_front();
                n_checked <= n_checked + 1;
                if (o_par_w !== want.par_w) begin
                    n_errors++;
                    $display("%0t: par_w mismatch, expected %0d, actual %0d",
                             $time, want.par_w, o_par_w);
                end
                if (o_par_h !== want.par_h) begin
                    n_errors++;
                    $display("%0t: par_h mismatch, expected %0d, actual %0d",
                             $time, want.par_h, o_par_h);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d of %0d transactions checked",
                     $time, n_checked, NUM_ITEMS);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        t_sizes s;
        int     pick;
        // The directed cases, in this order:
        // - all zero;
        // - zero frame width with the other sizes at full scale, so the other product
        //   is cut to 32 bits;
        // - zero display height;
        // - zero display width;
        // - zero frame height;
        // - all sizes at full scale;
        // - two cases where halving drives one term to zero;
        // - common video formats;
        // - a product of exactly 2^32-1;
        // - a product of exactly 2^32;
        // - all ones;
        // - large powers of two;
        // - alternating bit patterns;
        // - the largest 32-bit primes, then one small case with the ratio 2:3.
        pending_sizes.push_back('{32'd0, 32'd0, 32'd0, 32'd0});
        pending_sizes.push_back('{32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        pending_sizes.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0});
        pending_sizes.push_back('{32'd5, 32'd5, 32'd0, 32'd5});
        pending_sizes.push_back('{32'd9, 32'd0, 32'd3, 32'd7});
        pending_sizes.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        pending_sizes.push_back('{32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1});
        pending_sizes.push_back('{32'hFFFF_FFFF, 32'd1, 32'd1, 32'hFFFF_FFFF});
        pending_sizes.push_back('{32'd1920, 32'd1080, 32'd1920, 32'd1080});
        pending_sizes.push_back('{32'd720, 32'd576, 32'd1024, 32'd576});
        pending_sizes.push_back('{32'd1, 32'd65537, 32'd65535, 32'd1});
        pending_sizes.push_back('{32'd1, 32'd65536, 32'd65536, 32'd1});
        pending_sizes.push_back('{32'd1, 32'd1, 32'd1, 32'd1});
        pending_sizes.push_back('{32'h8000_0000, 32'd3, 32'd5, 32'h8000_0000});
        pending_sizes.push_back('{32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA});
        pending_sizes.push_back('{32'd4294967291, 32'd4294967279, 32'd1, 32'd1});
        pending_sizes.push_back('{32'd4294967291, 32'd4294967279, 32'd4294967291,
                                  32'd4294967279});
        pending_sizes.push_back('{32'd4294967291, 32'd4294967279, 32'd4294967279,
                                  32'd4294967291});
        pending_sizes.push_back('{32'd3, 32'd2, 32'd1, 32'd1});
        num_directed = pending_sizes.size();

        // Full-scale sizes cost about 30 reduction passes each, so they are rare.
        // Zero products skip the reduction and carry random full-width values, so every
        // input bit is driven both ways at little cost. Most items are small or of
        // video scale and need one pass.
        while (pending_sizes.size() < NUM_ITEMS) begin
            s.frame_w = $urandom();
            s.frame_h = $urandom();
            s.disp_w  = $urandom();
            s.disp_h  = $urandom();
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                // Full-scale sizes: many passes of halving and reduction.
            end else if (pick < 13) begin
                case ($urandom_range(0, 3))
                    0: s.frame_w = '0;
                    1: s.frame_h = '0;
                    2: s.disp_w  = '0;
                    default: s.disp_h = '0;
                endcase
                if ($urandom_range(0, 3) == 0) begin
                    case ($urandom_range(0, 3))
                        0: s.frame_w = '0;
                        1: s.frame_h = '0;
                        2: s.disp_w  = '0;
                        default: s.disp_h = '0;
                    endcase
                end
            end else if (pick < 23) begin
                // Products just past 32 bits take a few passes.
                s.frame_w = $urandom_range(1, 1 << 18);
                s.frame_h = $urandom_range(1, 1 << 18);
                s.disp_w  = $urandom_range(1, 1 << 18);
                s.disp_h  = $urandom_range(1, 1 << 18);
            end else if (pick < 60) begin
                s.frame_w = $urandom_range(1, 4095);
                s.frame_h = $urandom_range(1, 4095);
                s.disp_w  = $urandom_range(1, 4095);
                s.disp_h  = $urandom_range(1, 4095);
            end else begin
                // Video-like sizes share large common factors, so the GCD does real
                // work in this group.
                s.frame_w = 16 * $urandom_range(1, 256);
                s.frame_h = 8 * $urandom_range(1, 270);
                s.disp_w  = 2 * $urandom_range(1, 2048);
                s.disp_h  = ($urandom_range(0, 1) == 0) ? s.frame_h
                                                       : 8 * $urandom_range(1, 270);
            end
            pending_sizes.push_back(s);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (n_accepted == NUM_ITEMS);
        wait (n_checked == n_accepted);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        @(negedge i_clk);

        $display("Checked %0d transactions: %0d directed, %0d with a zero product,",
                 n_checked, num_directed, n_zero_prod);
        $display("%0d with a size wider than 16 bits; %0d mismatches found.",
                 n_big_field, n_errors);
        if (n_errors == 0 && expected_par.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
